### sv/rda_pkg.sv
// Shared constants for the rational duration accumulator.
// No dependencies; imported by every module of the block.
package rda_pkg;

  // Default word width of numerators; denominators are one bit narrower.
  localparam int DEF_WIDTH = 32;

  // Configuration register index port width and register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_NUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BAR_DEN = CFG_IDX_W'(1);

endpackage

### sv/rda_mul.sv
// Shared signed multiplier with a registered product.
// Depends on rda_pkg for the default width.
module rda_mul import rda_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                      clk_i,
  input  logic signed [WIDTH-1:0]   a_i,
  input  logic signed [WIDTH-1:0]   b_i,
  output logic signed [2*WIDTH-1:0] p_o
);

  logic signed [2*WIDTH-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### sv/rda_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on rda_pkg for the default width; operands are 2*WIDTH bits.
module rda_div import rda_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*WIDTH-1:0]   dividend_i,
  input  logic [2*WIDTH-1:0]   divisor_i,
  output logic                 done_o,
  output logic [2*WIDTH-1:0]   quo_o,
  output logic [2*WIDTH-1:0]   rem_o
);

  localparam int DW    = 2 * WIDTH;
  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // trial stays below twice the divisor, so no borrow means it fits
        if (!diff[DW]) begin
          rem_q <= diff[DW-1:0];
          quo_q <= {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= trial[DW-1:0];
          quo_q <= {quo_q[DW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### sv/rational_duration_accumulator.sv
// Rational duration accumulator: top level, sequencer and accumulator state.
// Depends on rda_pkg, rda_mul and rda_div.
//
// Keeps a running sum num/den in lowest terms and adds one fraction per input
// beat, restarting from 0/1 first when restart is set. Each beat returns one
// result with the sum, a strictly-greater-than-bar flag and an overflow flag;
// on overflow or a zero denominator the stored sum is kept and reported. One
// beat is in work at a time and in_ready_o is low meanwhile. Every remainder
// step of the gcd search (their number is data dependent) and both final
// divisions go through one bit-serial divider that produces one quotient bit
// per cycle. Products go through one shared multiplier, five per beat, or two
// for a zero denominator, which skips straight to the bar comparison.
module rational_duration_accumulator import rda_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [WIDTH-2:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    restart_i,
  input  logic signed [WIDTH-1:0] add_num_i,
  input  logic [WIDTH-2:0]        add_den_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WIDTH-1:0] sum_num_o,
  output logic [WIDTH-2:0]        sum_den_o,
  output logic                    over_bar_o,
  output logic                    overflow_o
);

  localparam int DW = 2 * WIDTH;
  localparam logic [DW-1:0] LIM    = {{(DW-1){1'b0}}, 1'b1} << (WIDTH - 1);
  localparam logic [DW-1:0] LIM_M1 = LIM - 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_MBN, S_MAB, S_MDN, S_MDC, S_EUC, S_WEUC, S_WMAG,
    S_LDEN, S_WDEN, S_CHK, S_CMP1, S_CMP2, S_CMP3, S_FIN
  } state_e;

  state_e state_q;

  logic [WIDTH-2:0]        bar_num_q;
  logic [WIDTH-2:0]        bar_den_q;
  logic signed [WIDTH-1:0] acc_num_q;
  logic [WIDTH-2:0]        acc_den_q;

  logic                    restart_q;
  logic signed [WIDTH-1:0] add_num_q;
  logic [WIDTH-2:0]        add_den_q;

  logic signed [DW-1:0]    num_q;
  logic signed [DW-1:0]    lhs_q;
  logic [DW-1:0]           mag_q;
  logic [DW-1:0]           den_q;
  logic [DW-1:0]           n_q;
  logic [DW-1:0]           m_q;
  logic                    neg_q;
  logic                    ovf_q;
  logic                    over_q;

  logic                    out_valid_q;
  logic signed [WIDTH-1:0] sum_num_q;
  logic [WIDTH-2:0]        sum_den_q;
  logic                    over_bar_q;
  logic                    overflow_q;

  // multiplier and divider hookup
  logic signed [WIDTH-1:0] mul_a;
  logic signed [WIDTH-1:0] mul_b;
  logic signed [DW-1:0]    prod;
  logic                    div_start;
  logic [DW-1:0]           div_dividend;
  logic [DW-1:0]           div_divisor;
  logic                    div_done;
  logic [DW-1:0]           div_quo;
  logic [DW-1:0]           div_rem;

  logic signed [WIDTH-1:0] base_num;
  logic [WIDTH-2:0]        base_den;
  logic [DW-1:0]           prod_u;
  logic [DW-1:0]           mag_c;
  logic                    ovf_c;

  rda_mul #(.WIDTH(WIDTH)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rda_div #(.WIDTH(WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign base_num = restart_q ? '0 : acc_num_q;
  assign base_den = restart_q ? (WIDTH-1)'(1) : acc_den_q;
  assign prod_u   = prod;
  assign mag_c    = num_q[DW-1] ? (~num_q + 1'b1) : num_q;
  assign ovf_c    = (den_q > LIM_M1) || (neg_q ? (mag_q > LIM) : (mag_q > LIM_M1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MBN: begin
        mul_a = base_num;
        mul_b = {1'b0, add_den_q};
      end
      S_MAB: begin
        mul_a = add_num_q;
        mul_b = {1'b0, base_den};
      end
      S_MDN: begin
        mul_a = {1'b0, base_den};
        mul_b = {1'b0, add_den_q};
      end
      S_CMP1: begin
        mul_a = acc_num_q;
        mul_b = {1'b0, bar_den_q};
      end
      S_CMP2: begin
        mul_a = {1'b0, bar_num_q};
        mul_b = {1'b0, acc_den_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      S_EUC: begin
        div_start = 1'b1;
        // once the remainder hits zero, n holds the gcd
        if (m_q == '0) begin
          div_dividend = mag_q;
          div_divisor  = n_q;
        end else begin
          div_dividend = n_q;
          div_divisor  = m_q;
        end
      end
      S_LDEN: begin
        div_start    = 1'b1;
        div_dividend = den_q;
        div_divisor  = n_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_num_q <= (WIDTH-1)'(1);
      bar_den_q <= (WIDTH-1)'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BAR_NUM: bar_num_q <= cfg_data_i;
        REG_BAR_DEN: bar_den_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_num_q   <= '0;
      acc_den_q   <= (WIDTH-1)'(1);
      restart_q   <= 1'b0;
      add_num_q   <= '0;
      add_den_q   <= '0;
      num_q       <= '0;
      lhs_q       <= '0;
      mag_q       <= '0;
      den_q       <= '0;
      n_q         <= '0;
      m_q         <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sum_num_q   <= '0;
      sum_den_q   <= '0;
      over_bar_q  <= 1'b0;
      overflow_q  <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            restart_q <= restart_i;
            add_num_q <= add_num_i;
            add_den_q <= add_den_i;
            if (add_den_i == '0) begin
              ovf_q   <= 1'b1;
              state_q <= S_CMP1;
            end else begin
              ovf_q   <= 1'b0;
              state_q <= S_MBN;
            end
          end
        end
        S_MBN: state_q <= S_MAB;
        S_MAB: begin
          num_q   <= prod;
          state_q <= S_MDN;
        end
        S_MDN: begin
          num_q   <= num_q + prod;
          state_q <= S_MDC;
        end
        S_MDC: begin
          den_q   <= prod_u;
          mag_q   <= mag_c;
          neg_q   <= num_q[DW-1];
          if (mag_c > prod_u) begin
            n_q <= mag_c;
            m_q <= prod_u;
          end else begin
            n_q <= prod_u;
            m_q <= mag_c;
          end
          state_q <= S_EUC;
        end
        S_EUC: state_q <= (m_q == '0) ? S_WMAG : S_WEUC;
        S_WEUC: begin
          if (div_done) begin
            n_q     <= m_q;
            m_q     <= div_rem;
            state_q <= S_EUC;
          end
        end
        S_WMAG: begin
          if (div_done) begin
            mag_q   <= div_quo;
            state_q <= S_LDEN;
          end
        end
        S_LDEN: state_q <= S_WDEN;
        S_WDEN: begin
          if (div_done) begin
            den_q   <= div_quo;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          ovf_q <= ovf_c;
          if (!ovf_c) begin
            acc_num_q <= neg_q ? -mag_q[WIDTH-1:0] : mag_q[WIDTH-1:0];
            acc_den_q <= den_q[WIDTH-2:0];
          end
          state_q <= S_CMP1;
        end
        S_CMP1: state_q <= S_CMP2;
        S_CMP2: begin
          lhs_q   <= prod;
          state_q <= S_CMP3;
        end
        S_CMP3: begin
          over_q  <= (lhs_q > prod);
          state_q <= S_FIN;
        end
        S_FIN: begin
          // hold the finished beat until the output register frees up
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            sum_num_q   <= acc_num_q;
            sum_den_q   <= acc_den_q;
            over_bar_q  <= over_q;
            overflow_q  <= ovf_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sum_num_o   = sum_num_q;
  assign sum_den_o   = sum_den_q;
  assign over_bar_o  = over_bar_q;
  assign overflow_o  = overflow_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_den_q != '0)
    else $error("accumulator denominator is zero");

  a_div_by_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_divisor != '0)
    else $error("divider started with zero divisor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  a_acc_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(acc_num_q) || !$stable(acc_den_q) |-> $past(state_q == S_CHK))
    else $error("accumulator changed outside the check step");

endmodule

### tb/tb_top.sv
// Self-checking bench for rational_duration_accumulator: directed and random fractions
// across several bar-length settings, each result checked against an in-bench predictor.
// Depends on rda_pkg and the accumulator RTL.
module tb_top import rda_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = DEF_WIDTH;
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int TAIL_CYCLES = 7000;  // longer than the slowest beat

  typedef struct packed {
    logic         restart;
    logic [W-1:0] num;
    logic [W-2:0] den;
  } beat_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-2:0] den;
    logic         over_bar;
    logic         overflow;
  } sum_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_BAR_NUM;
  logic [W-2:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic restart_i = 1'b0;
  logic signed [W-1:0] add_num_i = '0;
  logic [W-2:0] add_den_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [W-1:0] sum_num_o;
  logic [W-2:0] sum_den_o;
  logic over_bar_o;
  logic overflow_o;

  rational_duration_accumulator #(.WIDTH(W)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .restart_i, .add_num_i, .add_den_i,
    .out_valid_o, .out_ready_i, .sum_num_o, .sum_den_o, .over_bar_o, .overflow_o
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // predictor state: running sum and bar length
  longint run_num = 0;
  longint run_den = 1;
  longint bar_num_cfg = 1;
  longint bar_den_cfg = 1;

  beat_t pending_beats[$];
  sum_t  sums_due[$];
  beat_t drive_beat;
  bit    calm_mode = 1'b0;
  int    beats_raised = 0;
  int    beats_taken = 0;
  int    sums_seen = 0;
  int    mismatches = 0;
  int    overflow_cnt = 0;
  int    over_bar_cnt = 0;
  int    send_gap = 0;
  int    recv_stall = 0;
  int    stalls_seen = 0;

  // Adds one fraction to the running sum; rejected sums leave the state alone.
  function automatic sum_t predict_sum(input beat_t b);
    longint base_num, base_den, total;
    longint unsigned mag, den, x, y, r, lim;
    logic neg, rejected;
    sum_t s;
    lim = 64'd1 << (W - 1);
    rejected = (b.den == '0);
    if (!rejected) begin
      base_num = b.restart ? 0 : run_num;
      base_den = b.restart ? 1 : run_den;
      total = base_num * longint'(b.den) + longint'($signed(b.num)) * base_den;
      den = base_den * longint'(b.den);
      neg = total < 0;
      mag = neg ? -total : total;
      x = (mag > den) ? mag : den;
      y = (mag > den) ? den : mag;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      mag = mag / x;
      den = den / x;
      // negative side reaches one further than positive
      if (den > lim - 1 || mag > (neg ? lim : lim - 1)) begin
        rejected = 1'b1;
      end else begin
        run_num = neg ? -longint'(mag) : longint'(mag);
        run_den = den;
      end
    end
    s.num = run_num[W-1:0];
    s.den = run_den[W-2:0];
    s.over_bar = (run_num * bar_den_cfg) > (bar_num_cfg * run_den);
    s.overflow = rejected;
    return s;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int unsigned pick;
    b.restart = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // note values: power of two times an odd tuplet factor
      b.den = (W-1)'((1 << $urandom_range(0, 5)) * (2 * $urandom_range(0, 3) + 1));
    end else if (pick < 85) begin
      b.den = (W-1)'($urandom_range(1, 1000));
    end else if (pick < 98) begin
      b.den = (W-1)'($urandom);
    end else begin
      b.den = '0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      b.num = $urandom_range(0, 14) - 7;
    end else if (pick < 90) begin
      b.num = $urandom_range(0, 131072) - 65536;
    end else begin
      b.num = $urandom;
    end
    return b;
  endfunction

  function automatic void push_beat(input logic restart, input logic [W-1:0] num,
                                    input logic [W-2:0] den);
    beat_t b;
    b.restart = restart;
    b.num = num;
    b.den = den;
    pending_beats.push_back(b);
  endfunction

  task automatic write_bar(input logic [CFG_IDX_W-1:0] idx, input logic [W-2:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BAR_NUM) begin
      bar_num_cfg = value;
    end else begin
      bar_den_cfg = value;
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || beats_raised != beats_taken || sums_due.size() != 0)
      @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
  endtask

  // input side: one beat at a time, random gap counted while the block is ready
  always @(negedge clk_i) begin : drive_inputs
    logic next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (!in_valid_i || beats_taken == beats_raised) begin
        next_valid = 1'b0;
        if (send_gap != 0) begin
          if (in_ready_o) send_gap--;
        end else if (pending_beats.size() != 0) begin
          drive_beat = pending_beats.pop_front();
          restart_i <= drive_beat.restart;
          add_num_i <= drive_beat.num;
          add_den_i <= drive_beat.den;
          next_valid = 1'b1;
          beats_raised++;
          send_gap = calm_mode ? 0 : $urandom_range(0, 13);
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // output side: new stall drawn per result, counted down while a result waits
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stalls_seen != sums_seen) begin
        stalls_seen = sums_seen;
        recv_stall = calm_mode ? 0 : $urandom_range(0, 13);
      end
      if (recv_stall != 0 && out_valid_o) recv_stall--;
      out_ready_i <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin : check_sums
    sum_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sums_seen++;
        if (sums_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sum %0d/%0d over_bar %0b overflow %0b",
                     sum_num_o, sum_den_o, over_bar_o, overflow_o);
        end else begin
          want = sums_due.pop_front();
          if (sum_num_o !== want.num || sum_den_o !== want.den ||
              over_bar_o !== want.over_bar || overflow_o !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"sum %0d: expected %0d/%0d over_bar %0b overflow %0b, ",
                        "got %0d/%0d over_bar %0b overflow %0b"},
                       sums_seen, $signed(want.num), want.den, want.over_bar,
                       want.overflow, sum_num_o, sum_den_o, over_bar_o, overflow_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_sum(drive_beat);
        if (want.overflow) overflow_cnt++;
        if (want.over_bar) over_bar_cnt++;
        sums_due.push_back(want);
        beats_taken++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d sums outstanding", CYCLE_LIMIT, sums_due.size());
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    logic [W-2:0] bn, bd;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // bar is 1/1 out of reset
    push_beat(1'b1, 1, 4);
    push_beat(1'b0, 3, 4);              // equals the bar, not above it
    push_beat(1'b0, 1, 1000000);
    push_beat(1'b0, -1, 1000000);
    push_beat(1'b0, -1, 1);             // sum hits zero
    push_beat(1'b1, 32'h8000_0000, 1);  // most negative numerator
    push_beat(1'b0, -1, 1);             // below range: rejected
    push_beat(1'b1, 32'h7FFF_FFFF, 1);
    push_beat(1'b0, 1, 1);              // above range: rejected
    push_beat(1'b1, 5, 0);              // zero denominator, restart not applied
    push_beat(1'b0, 5, 0);
    push_beat(1'b0, 0, 31'h7FFF_FFFF);
    push_beat(1'b1, 0, 31'h7FFF_FFFF);
    push_beat(1'b1, 1, 31'h7FFF_FFFF);
    push_beat(1'b0, 1, 31'h7FFF_FFFE);  // denominator too wide: rejected
    push_beat(1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_beat(1'b1, 32'h8000_0000, 31'h7FFF_FFFF);
    push_beat(1'b1, -1, 31'h7FFF_FFFF);
    push_beat(1'b0, 1, 31'h7FFF_FFFF);
    push_beat(1'b1, 6, 4);
    push_beat(1'b0, 1, 6);
    push_beat(1'b0, 32'h5555_5555, 31'h2AAA_AAAA);
    push_beat(1'b1, 32'hAAAA_AAAA, 31'h5555_5555);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin bn = 3; bd = 4; end
        1: begin bn = 0; bd = 1; end
        2: begin bn = 31'h7FFF_FFFF; bd = 1; end
        3: begin bn = 1; bd = 31'h7FFF_FFFF; end
        4: begin bn = 5; bd = 0; end           // zero bar denominator
        5: begin bn = 31'h7FFF_FFFF; bd = 31'h7FFF_FFFF; end
        default: begin bn = (W-1)'($urandom); bd = (W-1)'($urandom); end
      endcase
      write_bar(REG_BAR_NUM, bn);
      write_bar(REG_BAR_DEN, bd);
      calm_mode = (p % 3 == 1);
      repeat (125) pending_beats.push_back(random_beat());
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatches += sums_due.size();
    $display("%0d beats over 9 bar settings, %0d sums checked", beats_taken, sums_seen);
    $display("%0d rejected sums, %0d sums above the bar", overflow_cnt, over_bar_cnt);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rda_pkg.sv
sv/rda_mul.sv
sv/rda_div.sv
sv/rational_duration_accumulator.sv
tb/tb_top.sv
